>>> design/ogc_pkg.sv
// shared types, constants and fixed-point helpers for the outlet pressure ghost cell unit
// no dependencies; used by ogc_vdiv and outlet_pressure_ghost_cell_unit
package ogc_pkg;

  localparam int DEFAULT_MAX_LAYERS = 4;
  localparam int DEFAULT_FRAC_BITS  = 16;

  // velocity divider: one quotient bit per step, two steps per stage
  localparam int DIV_STEPS           = 32;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

  // register indexes (word address)
  localparam logic [1:0] REG_GAMMA_LESS_ONE     = 2'd0;
  localparam logic [1:0] REG_INV_GAMMA_LESS_ONE = 2'd1;
  localparam logic [1:0] REG_BACK_PRESSURE      = 2'd2;
  localparam logic [1:0] REG_GHOST_LAYERS       = 2'd3;

  localparam logic [30:0] RST_GAMMA_LESS_ONE     = 31'd26214;
  localparam logic [30:0] RST_INV_GAMMA_LESS_ONE = 31'd163840;
  localparam logic [30:0] RST_BACK_PRESSURE      = 31'd65536;
  localparam logic [2:0]  RST_GHOST_LAYERS       = 3'd2;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [30:0]        rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
    logic signed [31:0] e;
    logic [30:0]        rot_i;
    logic [30:0]        rot_g;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
  } face_item_t;

  // fields that pass to the result unchanged
  typedef struct packed {
    logic [30:0]        rho;
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic signed [31:0] mz;
  } pass_t;

  function automatic logic signed [63:0] mul33(logic signed [32:0] a, logic signed [32:0] b);
    logic signed [65:0] p;
    p = a * b;
    return p[63:0];
  endfunction

  // floor shift of an exact product, then saturate
  function automatic logic signed [31:0] fx_round(logic signed [63:0] p, int frac);
    logic signed [63:0] sh;
    sh = p >>> frac;
    if (sh > 64'(S32_MAX)) return S32_MAX;
    if (sh < 64'(S32_MIN)) return S32_MIN;
    return sh[31:0];
  endfunction

  function automatic logic signed [31:0] sat33(logic signed [32:0] s);
    if (s > 33'(S32_MAX)) return S32_MAX;
    if (s < 33'(S32_MIN)) return S32_MIN;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(logic signed [31:0] a, logic signed [31:0] b);
    return sat33(33'(a) - 33'(b));
  endfunction

endpackage

>>> design/ogc_vdiv.sv
// pipelined velocity divider: (momentum << frac) / density, truncated and saturated
// depends on ogc_pkg
module ogc_vdiv #(
  parameter int FRAC_BITS = ogc_pkg::DEFAULT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] mom,
  input  logic [30:0]        rho,
  output logic signed [31:0] vel
);
  import ogc_pkg::*;

  logic [31:0] mag;
  logic [63:0] dvd;
  logic        sat_in;

  logic [30:0] rr   [DIV_STAGES];
  logic [31:0] dlo  [DIV_STAGES];
  logic [31:0] qq   [DIV_STAGES];
  logic [30:0] dr   [DIV_STAGES];
  logic        neg  [DIV_STAGES];
  logic        sat  [DIV_STAGES];
  logic        zro  [DIV_STAGES];

  assign mag    = mom[31] ? 32'(-{mom[31], mom}) : mom[31:0];
  assign dvd    = 64'(mag) << FRAC_BITS;
  // quotient would reach 2^31: saturate (covers zero density too)
  assign sat_in = dvd >= (64'(rho) << 31);

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [30:0] r_in;
    logic [31:0] d_in;
    logic [31:0] q_in;
    logic [30:0] r_out;
    logic [31:0] d_out;
    logic [31:0] q_out;
    logic [30:0] dv;
    logic [32:0] t;
    logic        n_in;
    logic        st_in;
    logic        z_in;

    if (s == 0) begin : g_first
      assign r_in  = dvd[62:32];
      assign d_in  = dvd[31:0];
      assign q_in  = '0;
      assign dv    = rho;
      assign n_in  = mom[31];
      assign st_in = sat_in;
      assign z_in  = (mag == '0);
    end else begin : g_next
      assign r_in  = rr[s-1];
      assign d_in  = dlo[s-1];
      assign q_in  = qq[s-1];
      assign dv    = dr[s-1];
      assign n_in  = neg[s-1];
      assign st_in = sat[s-1];
      assign z_in  = zro[s-1];
    end

    always_comb begin
      r_out = r_in;
      d_out = d_in;
      q_out = q_in;
      t     = '0;
      for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
        t     = {1'b0, r_out, d_out[31]};
        d_out = {d_out[30:0], 1'b0};
        if (t >= 33'(dv)) begin
          t     = t - 33'(dv);
          q_out = {q_out[30:0], 1'b1};
        end else begin
          q_out = {q_out[30:0], 1'b0};
        end
        r_out = t[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[s]  <= r_out;
        dlo[s] <= d_out;
        qq[s]  <= q_out;
        dr[s]  <= dv;
        neg[s] <= n_in;
        sat[s] <= st_in;
        zro[s] <= z_in;
      end
    end
  end

  always_comb begin
    if (zro[DIV_STAGES-1]) begin
      vel = '0;
    end else if (sat[DIV_STAGES-1]) begin
      vel = neg[DIV_STAGES-1] ? S32_MIN : S32_MAX;
    end else if (neg[DIV_STAGES-1]) begin
      vel = -$signed(qq[DIV_STAGES-1]);
    end else begin
      vel = $signed(qq[DIV_STAGES-1]);
    end
  end

endmodule

>>> design/outlet_pressure_ghost_cell_unit.sv
// path from an accepted item to its first result item: input register, 16 divider stages,
// 9 arithmetic stages, output register. throughput: the output register hands out
// L = ghost_layers clamped to 1..MAX_LAYERS layer items per item, one per cycle while
// m_tready is high; the pipeline holds until the last layer is taken and takes an item
// every cycle otherwise. reset: sync active-high rst clears valid bits and restores registers
module outlet_pressure_ghost_cell_unit #(
  parameter int MAX_LAYERS = ogc_pkg::DEFAULT_MAX_LAYERS,
  parameter int FRAC_BITS  = ogc_pkg::DEFAULT_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // density, momentum_x, momentum_y, momentum_z, total_energy, rot_sq_interior,
  // rot_sq_ghost, normal_x, normal_y, normal_z, zero pad
  input  logic [279:0] s_tdata,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // ghost_density, ghost_momentum_x, ghost_momentum_y, ghost_momentum_z,
  // ghost_energy, layer_index, zero pad
  output logic [167:0] m_tdata,
  output logic         m_tlast,   // last_layer
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ogc_pkg::*;

  localparam logic signed [32:0] C09 = 33'((9 * (64'sd1 <<< FRAC_BITS) + 5) / 10);
  localparam logic signed [32:0] C11 = 33'((11 * (64'sd1 <<< FRAC_BITS) + 5) / 10);

  // configuration registers
  logic [30:0] gamma_less_one;
  logic [30:0] inverse_gamma_less_one;
  logic [30:0] back_pressure;
  logic [2:0]  ghost_layers;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_less_one         <= RST_GAMMA_LESS_ONE;
      inverse_gamma_less_one <= RST_INV_GAMMA_LESS_ONE;
      back_pressure          <= RST_BACK_PRESSURE;
      ghost_layers           <= RST_GHOST_LAYERS;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_GAMMA_LESS_ONE:     gamma_less_one         <= pwdata[30:0];
        REG_INV_GAMMA_LESS_ONE: inverse_gamma_less_one <= pwdata[30:0];
        REG_BACK_PRESSURE:      back_pressure          <= pwdata[30:0];
        REG_GHOST_LAYERS:       ghost_layers           <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GAMMA_LESS_ONE:     prdata = {1'b0, gamma_less_one};
      REG_INV_GAMMA_LESS_ONE: prdata = {1'b0, inverse_gamma_less_one};
      REG_BACK_PRESSURE:      prdata = {1'b0, back_pressure};
      REG_GHOST_LAYERS:       prdata = {29'b0, ghost_layers};
    endcase
  end

  // whole pipeline moves together; it holds only while the output register
  // still has layers of an item to hand out
  logic en;
  logic last;
  logic ovld;
  logic [2:0] cnt;
  logic [2:0] o_layers;

  assign last     = (3'(cnt + 3'd1) == o_layers);
  assign en       = !ovld || (m_tready && last);
  assign s_tready = en;

  // input register
  face_item_t p0;
  logic       v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      // density sits in the lowest bits of tdata
      p0 <= '{rho:   s_tdata[30:0],    mx:    s_tdata[62:31],
              my:    s_tdata[94:63],   mz:    s_tdata[126:95],
              e:     s_tdata[158:127], rot_i: s_tdata[189:159],
              rot_g: s_tdata[220:190], nx:    s_tdata[238:221],
              ny:    s_tdata[256:239], nz:    s_tdata[274:257]};
    end
  end

  // velocity dividers with matching payload delay line
  logic signed [31:0] ux, uy, uz;

  ogc_vdiv #(.FRAC_BITS(FRAC_BITS)) u_div_x (.clk, .en, .mom(p0.mx), .rho(p0.rho), .vel(ux));
  ogc_vdiv #(.FRAC_BITS(FRAC_BITS)) u_div_y (.clk, .en, .mom(p0.my), .rho(p0.rho), .vel(uy));
  ogc_vdiv #(.FRAC_BITS(FRAC_BITS)) u_div_z (.clk, .en, .mom(p0.mz), .rho(p0.rho), .vel(uz));

  face_item_t dly [DIV_STAGES];
  logic       dv  [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv[s] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= v0;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dv[s] <= dv[s-1];
      end
    end
    if (en) begin
      dly[0] <= p0;
      for (int s = 1; s < DIV_STAGES; s++) begin
        dly[s] <= dly[s-1];
      end
    end
  end

  face_item_t dq;
  assign dq = dly[DIV_STAGES-1];

  // stage a: squares and normal products
  logic               va;
  pass_t              a_pass;
  logic signed [31:0] a_sqx, a_sqy, a_sqz, a_e;
  logic signed [49:0] a_pnx, a_pny, a_pnz;
  logic [29:0]        a_hr;
  logic [30:0]        a_roti, a_rotg;

  // stage b: speed squared, flow direction, rotational terms
  logic               vb;
  pass_t              b_pass;
  logic signed [31:0] b_vsq, b_e, b_hri, b_hrg;
  logic               b_in;
  logic [29:0]        b_hr;

  // stage c: kinetic energy
  logic               vc;
  pass_t              c_pass;
  logic signed [31:0] c_ke, c_e, c_hri, c_hrg;
  logic               c_in;

  // stage d: bracket of the pressure equation
  logic               vd;
  pass_t              d_pass;
  logic signed [31:0] d_inner, d_ke, d_hrg;
  logic               d_in;

  // stage e: interior pressure
  logic               ve;
  pass_t              e_pass;
  logic signed [31:0] e_pint, e_ke, e_hrg;
  logic               e_in;

  // stage f: scaled pressures
  logic               vf;
  pass_t              f_pass;
  logic signed [31:0] f_p09, f_p11, f_ke, f_hrg;
  logic               f_in;

  // stage g: ghost pressure
  logic               vg;
  pass_t              g_pass;
  logic signed [31:0] g_pg, g_ke, g_hrg;

  // stage h: internal energy term
  logic               vh;
  pass_t              h_pass;
  logic signed [31:0] h_t, h_ke, h_hrg;

  // stage i: ghost energy
  logic               vi;
  pass_t              i_pass;
  logic signed [31:0] i_eg;

  logic signed [51:0] vn_sum;
  assign vn_sum = 52'(a_pnx) + 52'(a_pny) + 52'(a_pnz);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
    end else if (en) begin
      va <= dv[DIV_STAGES-1];
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      vi <= vh;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pass <= '{rho: dq.rho, mx: dq.mx, my: dq.my, mz: dq.mz};
      a_sqx  <= fx_round(mul33(33'(ux), 33'(ux)), FRAC_BITS);
      a_sqy  <= fx_round(mul33(33'(uy), 33'(uy)), FRAC_BITS);
      a_sqz  <= fx_round(mul33(33'(uz), 33'(uz)), FRAC_BITS);
      a_pnx  <= dq.nx * ux;
      a_pny  <= dq.ny * uy;
      a_pnz  <= dq.nz * uz;
      a_hr   <= dq.rho[30:1];   // 0.5 * rho, floor
      a_e    <= dq.e;
      a_roti <= dq.rot_i;
      a_rotg <= dq.rot_g;

      b_pass <= a_pass;
      b_vsq  <= add_sat(add_sat(a_sqx, a_sqy), a_sqz);
      b_in   <= vn_sum > 52'sd0;  // zero counts as outflow
      b_hri  <= fx_round(mul33($signed({3'b0, a_hr}), $signed({2'b0, a_roti})), FRAC_BITS);
      b_hrg  <= fx_round(mul33($signed({3'b0, a_hr}), $signed({2'b0, a_rotg})), FRAC_BITS);
      b_hr   <= a_hr;
      b_e    <= a_e;

      c_pass <= b_pass;
      c_ke   <= fx_round(mul33($signed({3'b0, b_hr}), 33'(b_vsq)), FRAC_BITS);
      c_e    <= b_e;
      c_hri  <= b_hri;
      c_hrg  <= b_hrg;
      c_in   <= b_in;

      d_pass  <= c_pass;
      d_inner <= add_sat(sub_sat(c_e, c_ke), c_hri);
      d_ke    <= c_ke;
      d_hrg   <= c_hrg;
      d_in    <= c_in;

      e_pass <= d_pass;
      e_pint <= fx_round(mul33($signed({2'b0, gamma_less_one}), 33'(d_inner)), FRAC_BITS);
      e_ke   <= d_ke;
      e_hrg  <= d_hrg;
      e_in   <= d_in;

      f_pass <= e_pass;
      f_p09  <= fx_round(mul33(C09, 33'(e_pint)), FRAC_BITS);
      f_p11  <= fx_round(mul33(C11, 33'(e_pint)), FRAC_BITS);
      f_ke   <= e_ke;
      f_hrg  <= e_hrg;
      f_in   <= e_in;

      // inflow: 0.9 p, outflow: min(1.1 p, back pressure)
      g_pass <= f_pass;
      if (f_in) begin
        g_pg <= f_p09;
      end else if (f_p11 < $signed({1'b0, back_pressure})) begin
        g_pg <= f_p11;
      end else begin
        g_pg <= $signed({1'b0, back_pressure});
      end
      g_ke  <= f_ke;
      g_hrg <= f_hrg;

      h_pass <= g_pass;
      h_t    <= fx_round(mul33(33'(g_pg), $signed({2'b0, inverse_gamma_less_one})), FRAC_BITS);
      h_ke   <= g_ke;
      h_hrg  <= g_hrg;

      i_pass <= h_pass;
      i_eg   <= sub_sat(add_sat(h_t, h_ke), h_hrg);
    end
  end

  // output register: repeats the item once per ghost layer
  pass_t              o_pass;
  logic signed [31:0] o_eg;
  logic [2:0]         layers_eff;

  always_comb begin
    if (ghost_layers == 3'd0) begin
      layers_eff = 3'd1;
    end else if ({1'b0, ghost_layers} > 4'(MAX_LAYERS)) begin
      layers_eff = 3'(MAX_LAYERS);
    end else begin
      layers_eff = ghost_layers;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
      cnt  <= '0;
    end else if (en) begin
      ovld <= vi;
      cnt  <= '0;
    end else if (m_tready) begin
      cnt <= 3'(cnt + 3'd1);
    end
    if (en) begin
      o_pass   <= i_pass;
      o_eg     <= i_eg;
      o_layers <= layers_eff;
    end
  end

  assign m_tvalid = ovld;
  assign m_tlast  = last;
  assign m_tdata  = {7'b0, cnt[1:0], o_eg, o_pass.mz, o_pass.my, o_pass.mx, o_pass.rho};

`ifndef SYNTHESIS
  // input side opens only when the output register is free or finishing
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || (m_tready && m_tlast)))
    else $error("s_tready does not follow output state");

  // layer counter stays below the layer count
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cnt < o_layers))
    else $error("layer counter out of range");

  // a taken layer other than the last is followed by the next layer of the same item
  a_layer_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && (cnt == 3'($past(cnt) + 3'd1)) && $stable(o_eg)))
    else $error("layer sequence broken");
`endif

endmodule
